@@ rtl/core/lgw_pkg.sv @@
package lgw_pkg;

    localparam int GRID_WIDTH  = 42;
    localparam int GRID_HEIGHT = 24;

    // 1.0 in Q1.16
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam int CFG_DATA_W = 21;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STYLE_MODE    = 3'd0,
        CFG_DOT_EDGE      = 3'd1,
        CFG_BOX_X_MIN     = 3'd2,
        CFG_BOX_X_MAX     = 3'd3,
        CFG_BOX_Y_MIN     = 3'd4,
        CFG_BOX_Y_MAX     = 3'd5,
        CFG_BASE_COLOUR   = 3'd6,
        CFG_ACTIVE_COLOUR = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        STYLE_STATIC = 3'd0,
        STYLE_VFILL  = 3'd1,
        STYLE_HFILL  = 3'd2,
        STYLE_DOT    = 3'd3,
        STYLE_ARC    = 3'd4,
        STYLE_GLOW   = 3'd5
    } t_style;

    typedef struct packed {
        logic [2:0]  style_mode;
        logic [1:0]  dot_edge;
        logic [11:0] box_x_min;
        logic [11:0] box_x_max;
        logic [11:0] box_y_min;
        logic [11:0] box_y_max;
        logic [20:0] base_colour;
        logic [20:0] active_colour;
    } t_cfg;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_pipe_ctrl;

endpackage

@@ rtl/core/lgw_cfg_regs.sv @@
module lgw_cfg_regs import lgw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.style_mode    <= STYLE_STATIC;
            r_cfg.dot_edge      <= 2'd1;
            r_cfg.box_x_min     <= '0;
            r_cfg.box_x_max     <= '0;
            r_cfg.box_y_min     <= '0;
            r_cfg.box_y_max     <= '0;
            r_cfg.base_colour   <= '0;
            r_cfg.active_colour <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_STYLE_MODE:    r_cfg.style_mode    <= i_cfg_data[2:0];
                CFG_DOT_EDGE:      r_cfg.dot_edge      <= i_cfg_data[1:0];
                CFG_BOX_X_MIN:     r_cfg.box_x_min     <= i_cfg_data[11:0];
                CFG_BOX_X_MAX:     r_cfg.box_x_max     <= i_cfg_data[11:0];
                CFG_BOX_Y_MIN:     r_cfg.box_y_min     <= i_cfg_data[11:0];
                CFG_BOX_Y_MAX:     r_cfg.box_y_max     <= i_cfg_data[11:0];
                CFG_BASE_COLOUR:   r_cfg.base_colour   <= i_cfg_data[20:0];
                CFG_ACTIVE_COLOUR: r_cfg.active_colour <= i_cfg_data[20:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/lgw_shade_pipe.sv @@
module lgw_shade_pipe import lgw_pkg::*; (
    input  logic        i_clk,
    input  t_cfg        i_cfg,
    input  t_pipe_ctrl  i_ctrl,
    input  logic [7:0]  i_pixel_x,
    input  logic [7:0]  i_pixel_y,
    input  logic        i_touch_active,
    input  logic [16:0] i_touch_norm_x,
    input  logic [16:0] i_touch_norm_y,
    input  logic [16:0] i_touch_pressure,
    output logic [5:0]  o_out_x,
    output logic [4:0]  o_out_y,
    output logic [6:0]  o_out_red,
    output logic [6:0]  o_out_green,
    output logic [6:0]  o_out_blue
);

    // quadrant clockwise from up, from sign and zero flags of u (right) and v (up)
    function automatic logic [1:0] quadrant(input logic u_neg, input logic u_zero,
                                            input logic v_neg, input logic v_zero);
        logic [1:0] q;
        if (!u_neg && !v_neg && !v_zero)
            q = 2'd0;
        else if (!u_neg && !u_zero && (v_neg || v_zero))
            q = 2'd1;
        else if ((u_neg || u_zero) && v_neg)
            q = 2'd2;
        else
            q = 2'd3;
        return q;
    endfunction

    // shift right by 20 with rounding toward zero
    function automatic logic signed [12:0] trunc20(input logic signed [31:0] n);
        logic [31:0] mag;
        logic [12:0] q;
        mag = n[31] ? (32'd0 - n) : n;
        q   = {1'b0, mag[31:20]};
        return n[31] ? $signed(13'd0 - q) : $signed(q);
    endfunction

    // ---------------- stage 1: box terms and products
    logic signed [11:0] w_xmin, w_xmax, w_ymin, w_ymax;
    logic signed [12:0] w_w, w_h, w_sum_x, w_sum_y;
    logic signed [18:0] w_sx, w_sy;
    logic [6:0]         w_px, w_py;
    logic [16:0]        w_t, w_tc;

    assign w_xmin  = $signed(i_cfg.box_x_min);
    assign w_xmax  = $signed(i_cfg.box_x_max);
    assign w_ymin  = $signed(i_cfg.box_y_min);
    assign w_ymax  = $signed(i_cfg.box_y_max);
    assign w_w     = 13'(w_xmax) - 13'(w_xmin);
    assign w_h     = 13'(w_ymax) - 13'(w_ymin);
    assign w_sum_x = 13'(w_xmin) + 13'(w_xmax);
    assign w_sum_y = 13'(w_ymin) + 13'(w_ymax);
    assign w_sx    = $signed({1'b0, i_touch_norm_x, 1'b0}) - 19'sd65536;
    assign w_sy    = 19'sd65536 - $signed({1'b0, i_touch_norm_y, 1'b0});
    assign w_px    = i_pixel_x[6:0];
    assign w_py    = i_pixel_y[6:0];
    assign w_t     = (i_touch_pressure > ONE_Q16) ? ONE_Q16 : i_touch_pressure;
    assign w_tc    = ONE_Q16 - w_t;

    logic [6:0]         r_s1_px, r_s1_py;
    logic               r_s1_active, r_s1_w_pos, r_s1_h_pos, r_s1_ny_zero;
    logic signed [31:0] r_s1_fu, r_s1_fv;
    logic signed [30:0] r_s1_pnx, r_s1_pny;
    logic signed [14:0] r_s1_pu, r_s1_pv;
    logic signed [13:0] r_s1_hlhs, r_s1_vlhs;
    logic [23:0]        r_s1_ga [3];
    logic [23:0]        r_s1_gb [3];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en1) begin
            r_s1_px      <= w_px;
            r_s1_py      <= w_py;
            r_s1_active  <= i_touch_active;
            r_s1_w_pos   <= (w_w > 13'sd0);
            r_s1_h_pos   <= (w_h > 13'sd0);
            r_s1_ny_zero <= (i_touch_norm_y == 17'd0);
            r_s1_fu      <= w_w * w_sx;
            r_s1_fv      <= w_h * w_sy;
            r_s1_pnx     <= $signed({1'b0, i_touch_norm_x}) * w_w;
            r_s1_pny     <= $signed({1'b0, i_touch_norm_y}) * w_h;
            r_s1_pu      <= $signed({3'b0, w_px, 5'b10000}) - 15'(w_sum_x);
            r_s1_pv      <= 15'(w_sum_y) - $signed({3'b0, w_py, 5'b10000});
            r_s1_hlhs    <= $signed({3'b0, w_px, 4'b1000}) - 14'(w_xmin);
            r_s1_vlhs    <= $signed({3'b0, w_py, 4'b1000}) - 14'(w_ymin);
            for (int ch = 0; ch < 3; ch++) begin
                r_s1_ga[ch] <= i_cfg.base_colour[ch*7 +: 7] * w_tc;
                r_s1_gb[ch] <= i_cfg.active_colour[ch*7 +: 7] * w_t;
            end
        end
    end

    // ---------------- stage 2: fill compares, dot centre, cross products, blend
    logic signed [31:0] w_hlhs_q, w_vlhs_q, w_dsum_x, w_dsum_y, w_fv_adj;
    logic signed [14:0] w_pv_adj;
    logic               w_hfill, w_vfill;
    logic [23:0]        w_gsum [3];
    logic [20:0]        n_s2_glow;

    assign w_hlhs_q = {{2{r_s1_hlhs[13]}}, r_s1_hlhs, 16'h0};
    assign w_vlhs_q = {{2{r_s1_vlhs[13]}}, r_s1_vlhs, 16'h0};
    assign w_hfill  = !r_s1_w_pos || (w_hlhs_q <= 32'(r_s1_pnx));
    assign w_vfill  = r_s1_h_pos ? (w_vlhs_q >= 32'(r_s1_pny)) : r_s1_ny_zero;
    assign w_dsum_x = $signed({{4{w_xmin[11]}}, w_xmin, 16'h0}) + 32'(r_s1_pnx);
    assign w_dsum_y = $signed({{4{w_ymin[11]}}, w_ymin, 16'h0}) + 32'(r_s1_pny);
    // a vector of length zero counts as pointing straight up
    assign w_pv_adj = (r_s1_pu == 15'sd0 && r_s1_pv == 15'sd0) ? 15'sd1 : r_s1_pv;
    assign w_fv_adj = (r_s1_fu == 32'sd0 && r_s1_fv == 32'sd0) ? 32'sd1 : r_s1_fv;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            w_gsum[ch]            = r_s1_ga[ch] + r_s1_gb[ch];
            n_s2_glow[ch*7 +: 7]  = w_gsum[ch][22:16];
        end
    end

    logic [6:0]         r_s2_px, r_s2_py;
    logic               r_s2_active, r_s2_hfill, r_s2_vfill;
    logic signed [12:0] r_s2_cx, r_s2_cy;
    logic signed [46:0] r_s2_cross_a, r_s2_cross_b;
    logic [1:0]         r_s2_qa, r_s2_qb;
    logic [20:0]        r_s2_glow;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en2) begin
            r_s2_px      <= r_s1_px;
            r_s2_py      <= r_s1_py;
            r_s2_active  <= r_s1_active;
            r_s2_hfill   <= w_hfill;
            r_s2_vfill   <= w_vfill;
            r_s2_cx      <= trunc20(w_dsum_x);
            r_s2_cy      <= trunc20(w_dsum_y);
            r_s2_cross_a <= r_s1_pu * w_fv_adj;
            r_s2_cross_b <= w_pv_adj * r_s1_fu;
            r_s2_qa      <= quadrant(r_s1_pu[14], r_s1_pu == 15'sd0,
                                     w_pv_adj[14], w_pv_adj == 15'sd0);
            r_s2_qb      <= quadrant(r_s1_fu[31], r_s1_fu == 32'sd0,
                                     w_fv_adj[31], w_fv_adj == 32'sd0);
            r_s2_glow    <= n_s2_glow;
        end
    end

    // ---------------- stage 3: dot and arc tests, colour select
    logic signed [14:0] w_half, w_pxs, w_pys, w_cx, w_cy;
    logic               w_dot, w_arc, w_lit;
    logic [20:0]        n_s3_colour;

    assign w_half = {14'd0, i_cfg.dot_edge[1]};
    assign w_pxs  = $signed({8'd0, r_s2_px});
    assign w_pys  = $signed({8'd0, r_s2_py});
    assign w_cx   = 15'(r_s2_cx);
    assign w_cy   = 15'(r_s2_cy);
    assign w_dot  = (w_pxs >= w_cx - w_half) && (w_pxs <= w_cx + w_half) &&
                    (w_pys >= w_cy - w_half) && (w_pys <= w_cy + w_half);
    assign w_arc  = (r_s2_qa != r_s2_qb) ? (r_s2_qa < r_s2_qb)
                                         : (r_s2_cross_a <= r_s2_cross_b);

    always_comb begin
        case (i_cfg.style_mode)
            STYLE_VFILL: w_lit = r_s2_vfill;
            STYLE_HFILL: w_lit = r_s2_hfill;
            STYLE_DOT:   w_lit = w_dot;
            STYLE_ARC:   w_lit = w_arc;
            default:     w_lit = 1'b0;
        endcase
        n_s3_colour = i_cfg.base_colour;
        if (r_s2_active && i_cfg.style_mode == STYLE_GLOW)
            n_s3_colour = r_s2_glow;
        if (r_s2_active && w_lit)
            n_s3_colour = i_cfg.active_colour;
    end

    logic [5:0]  r_s3_x;
    logic [4:0]  r_s3_y;
    logic [20:0] r_s3_colour;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en3) begin
            r_s3_x      <= r_s2_px[5:0];
            r_s3_y      <= r_s2_py[4:0];
            r_s3_colour <= n_s3_colour;
        end
    end

    assign o_out_x     = r_s3_x;
    assign o_out_y     = r_s3_y;
    assign o_out_red   = r_s3_colour[20:14];
    assign o_out_green = r_s3_colour[13:7];
    assign o_out_blue  = r_s3_colour[6:0];

endmodule

@@ rtl/core/led_grid_widget_pixel_shader.sv @@
// Pixel shader for a widget drawn on a 42x24 LED grid.
// Input channel (i_in_valid / o_in_ready): one shape pixel plus the touch
// state. Pixels outside the grid are taken and dropped without a result.
// Output channel (o_out_valid / i_out_ready): grid position and colour of
// each pixel that lies on the grid, in input order.
// Config channel (i_cfg_valid / o_cfg_ready): index and data of one
// register; always ready, write only while no item is in flight.
// Pipeline: three register stages; a result is valid once its item has passed
// through stages one and two into the output stage.
// Throughput: one item per cycle while the receiver does not stall, set by the
// three-stage pipeline with its multipliers in stages one and two.
// When the receiver stalls, the output stage holds its item and the stages
// behind it fill; o_in_ready drops only when all three stages hold items.
// Reset empties the pipeline and loads the register reset values
// (static style, dot size 1, zero box and colours).
module led_grid_widget_pixel_shader import lgw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_pixel_x,
    input  logic [7:0]            i_pixel_y,
    input  logic                  i_touch_active,
    input  logic [16:0]           i_touch_norm_x,
    input  logic [16:0]           i_touch_norm_y,
    input  logic [16:0]           i_touch_pressure,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [5:0]            o_out_x,
    output logic [4:0]            o_out_y,
    output logic [6:0]            o_out_red,
    output logic [6:0]            o_out_green,
    output logic [6:0]            o_out_blue
);

    t_cfg       w_cfg;
    t_pipe_ctrl w_ctrl;
    logic       w_in_grid;
    logic       r_v1, r_v2, r_v3;

    assign o_cfg_ready = 1'b1;

    lgw_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    assign w_in_grid = !i_pixel_x[7] && ({1'b0, i_pixel_x} < 9'(GRID_WIDTH)) &&
                       !i_pixel_y[7] && ({1'b0, i_pixel_y} < 9'(GRID_HEIGHT));

    // a stage moves when it is empty or the stage ahead moves
    assign w_ctrl.en3 = !r_v3 || i_out_ready;
    assign w_ctrl.en2 = !r_v2 || w_ctrl.en3;
    assign w_ctrl.en1 = !r_v1 || w_ctrl.en2;
    assign o_in_ready = w_ctrl.en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_ctrl.en1)
                r_v1 <= i_in_valid && w_in_grid;
            if (w_ctrl.en2)
                r_v2 <= r_v1;
            if (w_ctrl.en3)
                r_v3 <= r_v2;
        end
    end

    lgw_shade_pipe u_pipe (
        .i_clk            (i_clk),
        .i_cfg            (w_cfg),
        .i_ctrl           (w_ctrl),
        .i_pixel_x        (i_pixel_x),
        .i_pixel_y        (i_pixel_y),
        .i_touch_active   (i_touch_active),
        .i_touch_norm_x   (i_touch_norm_x),
        .i_touch_norm_y   (i_touch_norm_y),
        .i_touch_pressure (i_touch_pressure),
        .o_out_x          (o_out_x),
        .o_out_y          (o_out_y),
        .o_out_red        (o_out_red),
        .o_out_green      (o_out_green),
        .o_out_blue       (o_out_blue)
    );

    assign o_out_valid = r_v3;

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_v1 && r_v2 && r_v3))
        else $error("input blocked while a pipeline stage is empty");

    a_drop_off_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !w_in_grid) |=> !r_v1)
        else $error("off-grid item entered the pipeline");

    a_keep_on_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && w_in_grid) |=> r_v1)
        else $error("on-grid item lost at entry");

    a_out_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((int'(o_out_x) < GRID_WIDTH) && (int'(o_out_y) < GRID_HEIGHT)))
        else $error("result position outside the grid");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import lgw_pkg::*;

    localparam logic [2:0]  STYLE_SPARE_A   = 3'd6;
    localparam logic [2:0]  STYLE_SPARE_B   = 3'd7;
    localparam logic [20:0] WHITE           = 21'h1FFFFF;
    localparam longint      ONE             = 65536;
    localparam longint      NORM_MAX        = 131071;
    localparam longint      CELL            = 16;
    localparam longint      HALF_CELL       = 8;
    localparam int          SETTLE_CYCLES   = 8;
    localparam int          RANDOM_PHASES   = 16;
    localparam int          ITEMS_PER_PHASE = 50;
    localparam int          MAX_REPORTS     = 40;

    typedef struct packed {
        logic [7:0]  x;
        logic [7:0]  y;
        logic        act;
        logic [16:0] nx;
        logic [16:0] ny;
        logic [16:0] pr;
    } t_pixel;

    typedef struct packed {
        logic [5:0] x;
        logic [4:0] y;
        logic [6:0] red;
        logic [6:0] green;
        logic [6:0] blue;
    } t_shade;

    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY} t_rx_mode;
    typedef enum logic [1:0] {Q_UP_RIGHT, Q_DOWN_RIGHT, Q_DOWN_LEFT, Q_UP_LEFT} t_quadrant;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [7:0]            i_pixel_x;
    logic [7:0]            i_pixel_y;
    logic                  i_touch_active;
    logic [16:0]           i_touch_norm_x;
    logic [16:0]           i_touch_norm_y;
    logic [16:0]           i_touch_pressure;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [5:0]            o_out_x;
    logic [4:0]            o_out_y;
    logic [6:0]            o_out_red;
    logic [6:0]            o_out_green;
    logic [6:0]            o_out_blue;

    t_cfg     widget;
    t_shade   pending_shades[$];
    t_rx_mode rx_mode = RX_FREE;
    int       rx_left = 0;
    int       tx_gap_max = 0;
    int       burst_left = 0;
    int       n_errors = 0;
    int       n_items = 0;
    int       n_dropped = 0;
    int       n_checked = 0;
    int       n_setups = 0;

    led_grid_widget_pixel_shader uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_pixel_x        (i_pixel_x),
        .i_pixel_y        (i_pixel_y),
        .i_touch_active   (i_touch_active),
        .i_touch_norm_x   (i_touch_norm_x),
        .i_touch_norm_y   (i_touch_norm_y),
        .i_touch_pressure (i_touch_pressure),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_x          (o_out_x),
        .o_out_y          (o_out_y),
        .o_out_red        (o_out_red),
        .o_out_green      (o_out_green),
        .o_out_blue       (o_out_blue)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_quadrant quadrant_of(input longint u, input longint v);
        if (u >= 0 && v > 0) return Q_UP_RIGHT;
        if (u > 0 && v <= 0) return Q_DOWN_RIGHT;
        if (u <= 0 && v < 0) return Q_DOWN_LEFT;
        return Q_UP_LEFT;
    endfunction

    // Q1.16 times Q8.4 down to whole cells
    function automatic longint cell_toward_zero(input longint n);
        return (n >= 0) ? (n >>> 20) : -((-n) >>> 20);
    endfunction

    function automatic bit shade_pixel(input t_pixel p, output t_shade r);
        longint    px, py, nx, ny, pr, xmin, xmax, ymin, ymax, w, h;
        longint    half, cx, cy, pu, pv, fu, fv, t, a, b, c;
        t_quadrant qp, qf;
        logic [20:0] colour;
        bit        lit;
        px = longint'($signed(p.x));
        py = longint'($signed(p.y));
        nx = longint'(p.nx);
        ny = longint'(p.ny);
        pr = longint'(p.pr);
        xmin = longint'($signed(widget.box_x_min));
        xmax = longint'($signed(widget.box_x_max));
        ymin = longint'($signed(widget.box_y_min));
        ymax = longint'($signed(widget.box_y_max));
        w = xmax - xmin;
        h = ymax - ymin;
        colour = widget.base_colour;
        lit = 1'b0;
        r = '0;
        if (px < 0 || px >= GRID_WIDTH || py < 0 || py >= GRID_HEIGHT) return 1'b0;
        case (widget.style_mode)
            STYLE_VFILL: begin
                if (p.act)
                    lit = (h > 0) ? ((py * CELL + HALF_CELL - ymin) * ONE >= ny * h) : (ny == 0);
            end
            STYLE_HFILL: begin
                if (p.act)
                    lit = (w > 0) ? ((px * CELL + HALF_CELL - xmin) * ONE <= nx * w) : 1'b1;
            end
            STYLE_DOT: begin
                // size zero behaves as one, both give a half size of zero
                half = longint'(widget.dot_edge) >>> 1;
                cx = cell_toward_zero(xmin * ONE + nx * w);
                cy = cell_toward_zero(ymin * ONE + ny * h);
                lit = p.act && px >= cx - half && px <= cx + half &&
                      py >= cy - half && py <= cy + half;
            end
            STYLE_ARC: begin
                if (p.act) begin
                    // doubled coordinates around the box centre, up is positive
                    pu = px * 2 * CELL + CELL - (xmin + xmax);
                    pv = (ymin + ymax) - (py * 2 * CELL + CELL);
                    fu = w * (2 * nx - ONE);
                    fv = h * (ONE - 2 * ny);
                    if (pu == 0 && pv == 0) pv = 1;
                    if (fu == 0 && fv == 0) fv = 1;
                    qp = quadrant_of(pu, pv);
                    qf = quadrant_of(fu, fv);
                    lit = (qp != qf) ? (qp < qf) : (pu * fv - pv * fu <= 0);
                end
            end
            STYLE_GLOW: begin
                if (p.act) begin
                    t = (pr > ONE) ? ONE : pr;
                    for (int sh = 0; sh <= 14; sh += 7) begin
                        a = longint'(widget.base_colour[sh +: 7]);
                        b = longint'(widget.active_colour[sh +: 7]);
                        c = (a * (ONE - t) + b * t) >>> 16;
                        colour[sh +: 7] = c[6:0];
                    end
                end
            end
            default: ;
        endcase
        if (lit) colour = widget.active_colour;
        r.x = p.x[5:0];
        r.y = p.y[4:0];
        r.red = colour[20:14];
        r.green = colour[13:7];
        r.blue = colour[6:0];
        return 1'b1;
    endfunction

    function automatic t_pixel pix(input int x, input int y, input bit act,
                                   input int nx, input int ny, input int pr);
        t_pixel p;
        p.x = x[7:0];
        p.y = y[7:0];
        p.act = act;
        p.nx = nx[16:0];
        p.ny = ny[16:0];
        p.pr = pr[16:0];
        return p;
    endfunction

    function automatic t_cfg widget_cfg(input logic [2:0] style, input logic [1:0] dot,
                                        input int xmin, input int xmax,
                                        input int ymin, input int ymax,
                                        input logic [20:0] base, input logic [20:0] active);
        t_cfg c;
        c.style_mode = style;
        c.dot_edge = dot;
        c.box_x_min = xmin[11:0];
        c.box_x_max = xmax[11:0];
        c.box_y_min = ymin[11:0];
        c.box_y_max = ymax[11:0];
        c.base_colour = base;
        c.active_colour = active;
        return c;
    endfunction

    function automatic logic [16:0] rand_norm();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 17'(ONE);
            2:       return 17'($urandom_range(ONE + 1, NORM_MAX));
            default: return 17'($urandom_range(0, ONE));
        endcase
    endfunction

    // pick a norm that puts the finger near the given cell
    function automatic logic [16:0] aim_norm(input logic [7:0] pos,
                                             input logic [11:0] lo, input logic [11:0] hi);
        longint w, v, j;
        w = longint'($signed(hi)) - longint'($signed(lo));
        if (w <= 0) return rand_norm();
        j = longint'($urandom_range(0, CELL - 1));
        v = (longint'($signed(pos)) * CELL + j - longint'($signed(lo))) * ONE / w;
        if (v < 0) v = 0;
        if (v > NORM_MAX) v = NORM_MAX;
        return v[16:0];
    endfunction

    // box edges packed as {min, max}
    function automatic logic [23:0] rand_span(input int extent);
        int lo, hi;
        case ($urandom_range(0, 7))
            0: begin
                lo = $urandom_range(0, 4095) - 2048;
                hi = $urandom_range(0, 4095) - 2048;
            end
            1: begin
                lo = $urandom_range(0, extent) - 32;
                hi = lo;
            end
            2: begin
                lo = -2048;
                hi = 2047;
            end
            default: begin
                lo = $urandom_range(0, 96) - 48;
                hi = lo + $urandom_range(CELL, extent + 64);
            end
        endcase
        return {lo[11:0], hi[11:0]};
    endfunction

    function automatic void check_field(input string name, input logic [6:0] want,
                                        input logic [6:0] got);
        if (got !== want) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // receiver: always ready in free mode, else alternating ready and stall runs of random length
    always @(posedge i_clk) begin
        if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else if (rx_mode == RX_FREE) begin
            i_out_ready <= 1'b1;
        end else if (i_out_ready) begin
            i_out_ready <= 1'b0;
            rx_left <= $urandom_range(0, (rx_mode == RX_HEAVY) ? 12 : 2);
        end else begin
            i_out_ready <= 1'b1;
            rx_left <= $urandom_range(0, 8);
        end
    end

    always @(posedge i_clk) begin
        t_pixel p;
        t_shade s;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            p.x = i_pixel_x;
            p.y = i_pixel_y;
            p.act = i_touch_active;
            p.nx = i_touch_norm_x;
            p.ny = i_touch_norm_y;
            p.pr = i_touch_pressure;
            n_items++;
            if (shade_pixel(p, s))
                pending_shades = {pending_shades, s};
            else
                n_dropped++;
        end
    end

    always @(posedge i_clk) begin
        t_shade want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_shades.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: extra item at (%0d,%0d), expected none, got %0d %0d %0d",
                             $time, o_out_x, o_out_y, o_out_red, o_out_green, o_out_blue);
            end else begin
                want = pending_shades.pop_front();
                n_checked++;
                check_field("out_x", 7'(want.x), 7'(o_out_x));
                check_field("out_y", 7'(want.y), 7'(o_out_y));
                check_field("out_red", want.red, o_out_red);
                check_field("out_green", want.green, o_out_green);
                check_field("out_blue", want.blue, o_out_blue);
            end
        end
    end

    task automatic send_pixel(input t_pixel p);
        int gap;
        i_in_valid <= 1'b1;
        i_pixel_x <= p.x;
        i_pixel_y <= p.y;
        i_touch_active <= p.act;
        i_touch_norm_x <= p.nx;
        i_touch_norm_y <= p.ny;
        i_touch_pressure <= p.pr;
        do @(posedge i_clk); while (!o_in_ready);
        // valid stays up inside a burst, drops for the gap after it if the gap is not zero
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = (tx_gap_max > 0) ? $urandom_range(1, tx_gap_max) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic settle_pipeline();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_shades.size() != 0) @(posedge i_clk);
        // an off-grid item may still be in flight with nothing to wait for
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_widget(input t_cfg c, input bit junk);
        logic [20:0] field, mask, data;
        int          width;
        settle_pipeline();
        for (int i = CFG_STYLE_MODE; i <= CFG_ACTIVE_COLOUR; i++) begin
            case (t_cfg_idx'(i))
                CFG_STYLE_MODE:    begin field = 21'(c.style_mode); width = 3;  end
                CFG_DOT_EDGE:      begin field = 21'(c.dot_edge);   width = 2;  end
                CFG_BOX_X_MIN:     begin field = 21'(c.box_x_min);  width = 12; end
                CFG_BOX_X_MAX:     begin field = 21'(c.box_x_max);  width = 12; end
                CFG_BOX_Y_MIN:     begin field = 21'(c.box_y_min);  width = 12; end
                CFG_BOX_Y_MAX:     begin field = 21'(c.box_y_max);  width = 12; end
                CFG_BASE_COLOUR:   begin field = c.base_colour;     width = 21; end
                CFG_ACTIVE_COLOUR: begin field = c.active_colour;   width = 21; end
                default:           begin field = '0;                width = 0;  end
            endcase
            mask = (21'd1 << width) - 21'd1;
            // unused upper data bits get noise when asked
            data = junk ? 21'($urandom) : '0;
            i_cfg_valid <= 1'b1;
            i_cfg_index <= t_cfg_idx'(i);
            i_cfg_data <= (data & ~mask) | (field & mask);
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        widget = c;
        n_setups++;
    endtask

    task automatic test_reset_defaults();
        tx_gap_max = 2;
        rx_mode = RX_LIGHT;
        send_pixel(pix(0, 0, 1'b1, 0, 0, 0));
        send_pixel(pix(41, 23, 1'b1, 131071, 131071, 131071));
        send_pixel(pix(-1, 0, 1'b1, 0, 0, 0));
        send_pixel(pix(42, 23, 1'b0, 0, 0, 0));
        send_pixel(pix(5, 24, 1'b1, 65536, 65536, 65536));
    endtask

    task automatic test_fill_bars();
        load_widget(widget_cfg(STYLE_VFILL, 2'd1, 0, 672, 0, 384, '0, WHITE), 1'b0);
        send_pixel(pix(3, 12, 1'b1, 0, 32768, 0));
        send_pixel(pix(3, 11, 1'b1, 0, 32768, 0));
        send_pixel(pix(3, 20, 1'b0, 0, 32768, 0));
        // flat box: only an empty fill level lights
        load_widget(widget_cfg(STYLE_VFILL, 2'd1, 0, 672, 100, 100, '0, WHITE), 1'b0);
        send_pixel(pix(7, 7, 1'b1, 0, 0, 0));
        // zero width: the bar is always full
        load_widget(widget_cfg(STYLE_HFILL, 2'd2, 64, 64, 0, 384, WHITE, '0), 1'b0);
        send_pixel(pix(40, 2, 1'b1, 0, 0, 0));
    endtask

    task automatic test_dot();
        load_widget(widget_cfg(STYLE_DOT, 2'd0, 0, 672, 0, 384, 21'h00407F, 21'h1FC000), 1'b0);
        send_pixel(pix(21, 12, 1'b1, 32768, 32768, 0));
        send_pixel(pix(22, 12, 1'b1, 32768, 32768, 0));
        // negative centre of half a cell truncates to cell zero
        load_widget(widget_cfg(STYLE_DOT, 2'd3, -8, 8, -8, 8, 21'h00407F, 21'h1FC000), 1'b0);
        send_pixel(pix(1, 1, 1'b1, 0, 0, 0));
        send_pixel(pix(2, 0, 1'b1, 0, 0, 0));
    endtask

    task automatic test_arc();
        // box centre sits on the line between cells 20 and 21, at the centre of row 11
        load_widget(widget_cfg(STYLE_ARC, 2'd1, 0, 672, 0, 368, 21'h0F0F0F, 21'h10F0F0), 1'b0);
        send_pixel(pix(10, 11, 1'b1, 65536, 32768, 0));
        send_pixel(pix(10, 2, 1'b1, 32768, 32768, 0));
        send_pixel(pix(30, 11, 1'b1, 32768, 32768, 0));
        send_pixel(pix(20, 20, 1'b1, 65536, 32768, 0));
    endtask

    task automatic test_glow();
        load_widget(widget_cfg(STYLE_GLOW, 2'd1, 0, 0, 0, 0, WHITE, 21'h0A5A5A), 1'b0);
        send_pixel(pix(1, 1, 1'b1, 0, 0, 0));
        send_pixel(pix(2, 1, 1'b1, 0, 0, 32768));
        send_pixel(pix(3, 1, 1'b1, 0, 0, 131071));
        send_pixel(pix(4, 1, 1'b0, 0, 0, 65536));
    endtask

    task automatic test_spare_styles();
        load_widget(widget_cfg(STYLE_SPARE_A, 2'd1, 0, 672, 0, 384, 21'h123456, WHITE), 1'b0);
        send_pixel(pix(9, 9, 1'b1, 65536, 0, 65536));
        load_widget(widget_cfg(STYLE_SPARE_B, 2'd1, 0, 672, 0, 384, 21'h0ABCDE, WHITE), 1'b0);
        send_pixel(pix(9, 9, 1'b1, 65536, 0, 65536));
    endtask

    task automatic test_random();
        t_cfg        c;
        t_pixel      p;
        logic [23:0] xs, ys;
        logic [20:0] base, active;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            xs = rand_span(GRID_WIDTH * CELL);
            ys = rand_span(GRID_HEIGHT * CELL);
            if (ph == 4) begin
                xs = {12'h800, 12'h7FF};
                ys = {12'h800, 12'h7FF};
            end
            base = 21'($urandom);
            active = 21'($urandom);
            if (ph == 1) begin
                base = '0;
                active = WHITE;
            end else if (ph == 2) begin
                base = WHITE;
                active = '0;
            end
            c = widget_cfg((ph < 8) ? ph[2:0] : 3'($urandom_range(0, 7)), 2'($urandom),
                           xs[23:12], xs[11:0], ys[23:12], ys[11:0], base, active);
            load_widget(c, 1'b1);
            case (ph % 4)
                0:       begin tx_gap_max = 0; rx_mode = RX_FREE;  end
                1:       begin tx_gap_max = 3; rx_mode = RX_LIGHT; end
                2:       begin tx_gap_max = 8; rx_mode = RX_HEAVY; end
                default: begin tx_gap_max = 1; rx_mode = RX_HEAVY; end
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                p.x = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(0, GRID_WIDTH - 1));
                p.y = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(0, GRID_HEIGHT - 1));
                p.act = ($urandom_range(0, 3) != 0);
                p.nx = rand_norm();
                p.ny = rand_norm();
                p.pr = rand_norm();
                // a dot rarely lands on a random pixel, so steer the finger to it
                if (c.style_mode == STYLE_DOT && $urandom_range(0, 1) == 1) begin
                    p.nx = aim_norm(p.x, c.box_x_min, c.box_x_max);
                    p.ny = aim_norm(p.y, c.box_y_min, c.box_y_max);
                end
                send_pixel(p);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_pixel_x = '0;
        i_pixel_y = '0;
        i_touch_active = 1'b0;
        i_touch_norm_x = '0;
        i_touch_norm_y = '0;
        i_touch_pressure = '0;
        widget = widget_cfg(STYLE_STATIC, 2'd1, 0, 0, 0, 0, '0, '0);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_fill_bars();
        test_dot();
        test_arc();
        test_glow();
        test_spare_styles();
        test_random();
        settle_pipeline();

        $display("checked %0d shaded pixels, %0d of %0d items fell off the grid",
                 n_checked, n_dropped, n_items);
        $display("%0d widget setups: all style codes, dot sizes, box and colour extremes",
                 n_setups);
        if (n_errors == 0)
            $display("led_grid_widget_pixel_shader regression: pass");
        else
            $display("led_grid_widget_pixel_shader regression: fail");
        $finish;
    end

    initial begin
        #5000000;
        $display("timeout at %0t with %0d items still expected", $time, pending_shades.size());
        $display("led_grid_widget_pixel_shader regression: fail");
        $finish;
    end

endmodule
